### rtl/core/ca2_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ca2_pkg - shared types and constants for the CORDIC atan2 pipeline
// Angle table, scale constant and the payload structs carried between stages.
// ----------------------------------------------------------------------------
package ca2_pkg;

  localparam int DATA_W         = 32;
  localparam int ANGLE_W        = 19;
  localparam int RES_W          = 20;
  localparam int TABLE_LEN      = 30;
  localparam int ITERATIONS_DEF = 16;

  // 0x6488d, kept signed so the product stays two's complement
  localparam logic signed [RES_W-1:0] SCALE_FACTOR = 20'sh6488D;
  // pi in Q16.16, low 19 bits
  localparam logic [ANGLE_W-1:0]      PI_Q16       = 19'h3243F;

  // atan(2^-t) with 2^31 standing for pi
  localparam logic [DATA_W-1:0] ARC_TABLE [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // vector state handed from cell to cell
  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic              xneg;
    logic              zero;
    logic              ynz;
  } vec_t;

  // scaled angle before quadrant fix-up
  typedef struct packed {
    logic [RES_W-1:0] res;
    logic             xneg;
    logic             zero;
    logic             ynz;
  } scaled_t;

endpackage
`default_nettype wire

### rtl/core/ca2_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ca2_prep - input stage
// Registers a request, folds x into the right half plane and flags zero input.
// ----------------------------------------------------------------------------
module ca2_prep (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           up_valid,
  input  wire logic signed [ca2_pkg::DATA_W-1:0] y_value,
  input  wire logic signed [ca2_pkg::DATA_W-1:0] x_value,
  output logic                                up_ready,
  output logic                                dn_valid,
  output ca2_pkg::vec_t                       dn,
  input  wire logic                           dn_ready
);
  import ca2_pkg::*;

  vec_t vec_next;

  // fold x, note the special cases
  always_comb begin
    vec_next.xneg = x_value[DATA_W-1];
    vec_next.x    = x_value[DATA_W-1] ? (DATA_W'(0) - x_value) : x_value;
    vec_next.y    = y_value;
    vec_next.z    = '0;
    vec_next.zero = ((x_value | y_value) == '0);
    vec_next.ynz  = (y_value != '0);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn <= vec_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ca2_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ca2_cell - one CORDIC vectoring step
// Rotates toward the x axis by atan(2^-STEP) and registers the vector.
// ----------------------------------------------------------------------------
module ca2_cell #(
  parameter int STEP = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           up_valid,
  input  wire ca2_pkg::vec_t  up,
  output logic                up_ready,
  output logic                dn_valid,
  output ca2_pkg::vec_t       dn,
  input  wire logic           dn_ready
);
  import ca2_pkg::*;

  logic signed [DATA_W-1:0] dx;
  logic signed [DATA_W-1:0] dy;
  vec_t                     vec_next;

  // shift-add rotation, direction from the sign of y
  always_comb begin
    dx       = $signed(up.y) >>> STEP;
    dy       = $signed(up.x) >>> STEP;
    vec_next = up;
    if (up.y[DATA_W-1]) begin
      vec_next.x = up.x - dx;
      vec_next.y = up.y + dy;
      vec_next.z = up.z - ARC_TABLE[STEP];
    end else begin
      vec_next.x = up.x + dx;
      vec_next.y = up.y - dy;
      vec_next.z = up.z + ARC_TABLE[STEP];
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn <= vec_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ca2_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ca2_scale - rescale and quadrant fix-up
// Multiplies the angle accumulator down to Q16.16, then applies pi - angle
// for negative x and forces zero for a zero input. Two register stages.
// ----------------------------------------------------------------------------
module ca2_scale (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        up_valid,
  input  wire ca2_pkg::vec_t               up,
  output logic                             up_ready,
  output logic                             res_valid,
  output logic [ca2_pkg::ANGLE_W-1:0]      angle,
  input  wire logic                        res_stall
);
  import ca2_pkg::*;

  localparam int PROD_W = DATA_W + RES_W;

  logic signed [PROD_W-1:0] prod;
  scaled_t                  mul_next;
  scaled_t                  mul;
  logic                     mul_valid;
  logic                     mul_ready;
  logic                     out_ready;
  logic [ANGLE_W-1:0]       pi_sel;
  logic [ANGLE_W-1:0]       angle_next;

  // high word of z * 0x6488d; only its low 20 bits reach the result
  always_comb begin
    prod          = $signed(up.z) * SCALE_FACTOR;
    mul_next.res  = prod[PROD_W-1:DATA_W];
    mul_next.xneg = up.xneg;
    mul_next.zero = up.zero;
    mul_next.ynz  = up.ynz;
  end

  assign out_ready = !res_valid || !res_stall;
  assign mul_ready = !mul_valid || out_ready;
  assign up_ready  = mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && up_valid) begin
      mul <= mul_next;
    end
  end

  // left half plane: signed pi minus angle, +pi when y was zero
  always_comb begin
    pi_sel = (mul.res[RES_W-1] && mul.ynz) ? (ANGLE_W'(0) - PI_Q16) : PI_Q16;
    if (mul.zero) begin
      angle_next = '0;
    end else if (mul.xneg) begin
      angle_next = pi_sel - mul.res[ANGLE_W-1:0];
    end else begin
      angle_next = mul.res[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && mul_valid) begin
      angle <= angle_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/cordic_atan2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cordic_atan2 - four-quadrant arctangent by CORDIC vectoring
// Usage:
//   Request channel: y_value, x_value (signed Q16.16) with req_valid and
//   req_stall. A request is taken at a clock edge with req_valid high and
//   req_stall low.
//   Result channel: angle (signed Q16.16 radians, 19 bits) with res_valid
//   and res_stall; a result is taken when res_valid is high and res_stall low.
//   A request passes through one input stage, one cell per vectoring step,
//   a multiply stage and an output stage.
//   Throughput is one request per cycle while res_stall is low; every stage
//   is a register in the chain, so new requests enter as earlier ones move on.
//   When the receiver stalls, the result holds and upstream stages keep
//   filling empty slots; req_stall rises only once every stage is occupied.
//   Synchronous reset empties the pipeline; no request is pending after it.
// ----------------------------------------------------------------------------
module cordic_atan2 #(
  parameter int ITERATIONS = ca2_pkg::ITERATIONS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire logic signed [ca2_pkg::DATA_W-1:0] y_value,
  input  wire logic signed [ca2_pkg::DATA_W-1:0] x_value,
  output logic                                   res_valid,
  input  wire logic                              res_stall,
  output logic signed [ca2_pkg::ANGLE_W-1:0]     angle
);
  import ca2_pkg::*;

  vec_t               chain_vec   [ITERATIONS+1];
  logic               chain_valid [ITERATIONS+1];
  logic               chain_ready [ITERATIONS+1];
  logic               prep_ready;
  logic [ANGLE_W-1:0] angle_bits;

  assign req_stall = !prep_ready;
  assign angle     = $signed(angle_bits);

  // input stage
  ca2_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .y_value  (y_value),
    .x_value  (x_value),
    .up_ready (prep_ready),
    .dn_valid (chain_valid[0]),
    .dn       (chain_vec[0]),
    .dn_ready (chain_ready[0])
  );

  // row of vectoring cells
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    ca2_cell #(
      .STEP (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up       (chain_vec[i]),
      .up_ready (chain_ready[i]),
      .dn_valid (chain_valid[i+1]),
      .dn       (chain_vec[i+1]),
      .dn_ready (chain_ready[i+1])
    );
  end

  // rescale and quadrant fix-up
  ca2_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (chain_valid[ITERATIONS]),
    .up        (chain_vec[ITERATIONS]),
    .up_ready  (chain_ready[ITERATIONS]),
    .res_valid (res_valid),
    .angle     (angle_bits),
    .res_stall (res_stall)
  );

endmodule
`default_nettype wire

### dv/cordic_atan2_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_atan2_tb - self-checking bench for the CORDIC atan2 pipeline
// A queue-fed driver sends (y, x) requests. Each accepted request is run
// through a bit-exact arctangent predictor, and the expected angle is queued.
// A monitor checks each result in order. Both sides idle in random bursts,
// and the receiver once holds off long enough to back the pipeline up.
// ----------------------------------------------------------------------------
module cordic_atan2_tb;
  import ca2_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int LONG_HOLD_AT  = 150;   // results seen before the long hold
  localparam int LONG_HOLD_LEN = 200;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] x;
  } pair_t;

  typedef struct {
    logic [DATA_W-1:0]  y;
    logic [DATA_W-1:0]  x;
    logic [ANGLE_W-1:0] angle;
  } angle_check_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic signed [DATA_W-1:0] y_value = '0;
  logic signed [DATA_W-1:0] x_value = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic signed [ANGLE_W-1:0] angle;

  pair_t        pending_pairs[$];
  angle_check_t expected_angles[$];
  bit           idle_on = 1'b1;
  int           send_gap = 0;
  int           stall_left = 0;
  bit           long_hold_done = 1'b0;
  int           results_seen = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  cordic_atan2 dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .y_value   (y_value),
    .x_value   (x_value),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .angle     (angle)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // expected atan2: vectoring steps, rescale, quadrant fix-up, 32-bit wrap
  function automatic logic [ANGLE_W-1:0] atan2_angle(logic [DATA_W-1:0] y_in,
                                                     logic [DATA_W-1:0] x_in);
    logic [DATA_W-1:0] xv, yv, zv, dx, dy, r, pi_w;
    logic signed [63:0] prod;
    logic x_was_neg;
    int steps;
    int k;
    if ((x_in | y_in) == '0) return '0;
    steps = (ITERATIONS_DEF > TABLE_LEN) ? TABLE_LEN : ITERATIONS_DEF;
    x_was_neg = x_in[DATA_W-1];
    xv = x_was_neg ? (32'd0 - x_in) : x_in;   // most negative x wraps to itself
    yv = y_in;
    zv = '0;
    for (k = 0; k < steps; k++) begin
      dx = $signed(yv) >>> k;
      dy = $signed(xv) >>> k;
      if (yv[DATA_W-1]) begin
        xv = xv - dx;
        yv = yv + dy;
        zv = zv - ARC_TABLE[k];
      end else begin
        xv = xv + dx;
        yv = yv - dy;
        zv = zv + ARC_TABLE[k];
      end
    end
    prod = $signed(zv) * SCALE_FACTOR;
    r = prod[63:32];
    if (x_was_neg) begin
      pi_w = 32'(PI_Q16);
      if (r[DATA_W-1] && y_in != '0) pi_w = 32'd0 - pi_w;
      r = pi_w - r;
    end
    return r[ANGLE_W-1:0];
  endfunction

  function automatic pair_t mk_pair(logic [DATA_W-1:0] y, logic [DATA_W-1:0] x);
    pair_t p;
    p.y = y;
    p.x = x;
    return p;
  endfunction

  function automatic logic [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_small();
    return 32'(int'($urandom_range(0, 2097152)) - 1048576);
  endfunction

  // mix of full-range, sensor-sized, axis and corner requests
  function automatic pair_t random_pair();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return mk_pair($urandom, $urandom);
      4, 5, 6:    return mk_pair(pick_small(), pick_small());
      7:          return mk_pair('0, ($urandom_range(0, 1) != 0) ? $urandom : pick_small());
      8:          return mk_pair(($urandom_range(0, 1) != 0) ? $urandom : pick_small(), '0);
      default:    return mk_pair(pick_extreme(), pick_extreme());
    endcase
  endfunction

  // request driver: predicts on acceptance, holds payload while stalled
  always @(posedge clk) begin : driver
    pair_t p;
    if (rst) begin
      req_valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        angle_check_t c;
        c.y = y_value;
        c.x = x_value;
        c.angle = atan2_angle(y_value, x_value);
        expected_angles.push_back(c);
      end
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          p = pending_pairs.pop_front();
          y_value   <= p.y;
          x_value   <= p.x;
          req_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 15);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    angle_check_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen <= results_seen + 1;
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: angle=%h", angle);
      end else begin
        want = expected_angles.pop_front();
        if (angle !== want.angle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("angle mismatch: y=%h x=%h expected=%h actual=%h",
                     want.y, want.x, want.angle, angle);
        end
      end
    end
  end

  // receiver stall generation, hold length counted in cycles
  always @(posedge clk) begin : receiver
    if (rst) begin
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      // long hold so the pipeline fills and pushes back on the sender
      long_hold_done = 1'b1;
      stall_left = LONG_HOLD_LEN - 1;
      res_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: axes, corners, wrap of the most negative x, sign of pi
    pending_pairs.push_back(mk_pair(32'h0000_0000, 32'h0000_0000));
    pending_pairs.push_back(mk_pair(32'h0000_0000, 32'h0001_0000));
    pending_pairs.push_back(mk_pair(32'h0000_0000, 32'hFFFF_0000));
    pending_pairs.push_back(mk_pair(32'h0000_0000, 32'hFFFF_FFFF));
    pending_pairs.push_back(mk_pair(32'h0001_0000, 32'h0000_0000));
    pending_pairs.push_back(mk_pair(32'hFFFF_0000, 32'h0000_0000));
    pending_pairs.push_back(mk_pair(32'h0000_0000, 32'h8000_0000));
    pending_pairs.push_back(mk_pair(32'h0000_0001, 32'h8000_0000));
    pending_pairs.push_back(mk_pair(32'hFFFF_FFFF, 32'h8000_0000));
    pending_pairs.push_back(mk_pair(32'h8000_0000, 32'h0000_0000));
    pending_pairs.push_back(mk_pair(32'h8000_0000, 32'h8000_0000));
    pending_pairs.push_back(mk_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_pairs.push_back(mk_pair(32'h7FFF_FFFF, 32'h8000_0000));
    pending_pairs.push_back(mk_pair(32'h8000_0000, 32'h7FFF_FFFF));
    pending_pairs.push_back(mk_pair(32'h0000_0001, 32'h0000_0001));
    pending_pairs.push_back(mk_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_pairs.push_back(mk_pair(32'h0000_0001, 32'hFFFF_FFFF));
    pending_pairs.push_back(mk_pair(32'hFFFF_FFFF, 32'h0000_0001));
    pending_pairs.push_back(mk_pair(32'h0001_0000, 32'hFFFF_0000));
    pending_pairs.push_back(mk_pair(32'hFFFF_0000, 32'hFFFF_0000));
    pending_pairs.push_back(mk_pair(32'h7FFF_FFFF, 32'h0000_0000));
    pending_pairs.push_back(mk_pair(32'h0000_0000, 32'h7FFF_FFFF));
    pending_pairs.push_back(mk_pair(32'hAAAA_AAAA, 32'h5555_5555));
    pending_pairs.push_back(mk_pair(32'h5555_5555, 32'hAAAA_AAAA));

    // sender pauses until the pipeline has drained
    while (pending_pairs.size() != 0 || req_valid || expected_angles.size() != 0)
      @(negedge clk);

    // random, both sides idling; the long receiver hold lands in here
    for (k = 0; k < 600; k++) pending_pairs.push_back(random_pair());
    while (pending_pairs.size() != 0 || req_valid || expected_angles.size() != 0)
      @(negedge clk);

    for (k = 0; k < 300; k++) pending_pairs.push_back(random_pair());
    while (pending_pairs.size() != 0 || req_valid) @(negedge clk);

    // closing stretch at full rate
    idle_on = 1'b0;
    for (k = 0; k < 400; k++) pending_pairs.push_back(random_pair());
    while (pending_pairs.size() != 0 || req_valid || expected_angles.size() != 0)
      @(negedge clk);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
